/* design/velocity_profile_step_macros.svh */
// Assertion helpers used by the queue (vps_fifo).
`ifndef VELOCITY_PROFILE_STEP_MACROS_SVH
`define VELOCITY_PROFILE_STEP_MACROS_SVH

// Check that holds at every edge outside reset.
`define VPS_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check on the cycle after a trigger.
`define VPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/vps_pkg.sv */
package vps_pkg;

	// Queue between front and back
	localparam int FifoDepth = 4;
	localparam int FifoPtrW  = 2;
	localparam int FifoCntW  = 3;

	// Quotient bits kept by the two dividers
	localparam int Q1Bits = 31;
	localparam int Q2Bits = 34;

	// Velocities below this magnitude count as zero
	localparam logic signed [31:0] VelEps = 32'sd7;

	localparam logic [30:0] AccelMaxRst     = 31'd65536;
	localparam logic [30:0] AccelNominalRst = 31'd32768;
	localparam logic [30:0] SpeedMaxRst     = 31'd65536;
	localparam logic [16:0] TimeStepRst     = 17'd655;

	typedef enum logic [1:0] {
		REG_ACCEL_MAX     = 2'd0,
		REG_ACCEL_NOMINAL = 2'd1,
		REG_SPEED_MAX     = 2'd2,
		REG_TIME_STEP     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [30:0] accel_max;
		logic [30:0] accel_nominal;
		logic [30:0] speed_max;
		logic [16:0] dt;
	} cfg_t;

	// Classified beat handed from front to back
	typedef struct packed {
		logic signed [31:0] s;
		logic signed [31:0] vz;
		logic [31:0]        vmag;
		logic [31:0]        smag;
		logic               brake;
		logic [30:0]        dest;
		logic [30:0]        lim_now;
		logic [61:0]        dest_sq;
		logic [63:0]        v_sq;
		logic [31:0]        lim_brake;
		logic [31:0]        climit;
		logic [49:0]        p;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
		logic signed [31:0] r;
		if (x > 40'sh007fffffff)
			r = 32'sh7fffffff;
		else if (x < -40'sh0080000000)
			r = -32'sh80000000;
		else
			r = x[31:0];
		return r;
	endfunction

endpackage

/* design/velocity_profile_step.sv */
// One step of a trapezoidal velocity profile, signed Q16.16 throughout.
// Input channel: in_valid / in_stall with displacement_to_goal, actual_velocity,
// speed_target_now and speed_target_dest; a beat moves when in_valid is high
// and in_stall is low. Output channel: out_valid / out_stall with next_velocity,
// one result beat per input beat, in order.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 accel_max,
// 1 accel_nominal, 2 speed_max, 3 time_step); write only while idle.
// A beat runs through the front register, the queue and the back stages, chiefly
// the two restoring dividers (34 pipelined stages, one quotient bit each).
// Throughput is one beat per cycle while out_stall is low; at most 44 beats are
// in flight (front register, four queue entries and 39 back stages).
// A four-entry queue sits between the classifying front and the divider back.
// While out_valid and out_stall are high the whole back pipeline holds; the queue
// then fills and in_stall rises once it is full and the front register is occupied.
// Reset (arst_n low) empties every stage and the queue and loads the register
// defaults: accel_max 1.0, accel_nominal 0.5, speed_max 1.0, time_step 655.
module velocity_profile_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] displacement_to_goal,
	input  logic signed [31:0] actual_velocity,
	input  logic signed [31:0] speed_target_now,
	input  logic [30:0]        speed_target_dest,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] next_velocity,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_data
);

	logic [30:0] accel_max_q, accel_nominal_q, speed_max_q;
	logic [16:0] time_step_q;
	vps_pkg::cfg_t       cfg;
	vps_pkg::item_t      f_item, q_item;
	vps_pkg::fifo_stat_t q_stat;
	logic                push, pop;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_max_q     <= vps_pkg::AccelMaxRst;
			accel_nominal_q <= vps_pkg::AccelNominalRst;
			speed_max_q     <= vps_pkg::SpeedMaxRst;
			time_step_q     <= vps_pkg::TimeStepRst;
		end else if (cfg_we) begin
			case (vps_pkg::reg_idx_t'(cfg_index))
				vps_pkg::REG_ACCEL_MAX:     accel_max_q     <= cfg_data;
				vps_pkg::REG_ACCEL_NOMINAL: accel_nominal_q <= cfg_data;
				vps_pkg::REG_SPEED_MAX:     speed_max_q     <= cfg_data;
				vps_pkg::REG_TIME_STEP:     time_step_q     <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// zero time step acts as one LSB
	always_comb begin
		cfg.accel_max     = accel_max_q;
		cfg.accel_nominal = accel_nominal_q;
		cfg.speed_max     = speed_max_q;
		cfg.dt            = (time_step_q == '0) ? 17'd1 : time_step_q;
	end

	vps_front u_front (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg                  (cfg),
		.in_valid             (in_valid),
		.in_stall             (in_stall),
		.displacement_to_goal (displacement_to_goal),
		.actual_velocity      (actual_velocity),
		.speed_target_now     (speed_target_now),
		.speed_target_dest    (speed_target_dest),
		.q_full               (q_stat.full),
		.push                 (push),
		.item                 (f_item)
	);

	vps_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (f_item),
		.pop     (pop),
		.rd_item (q_item),
		.stat    (q_stat)
	);

	vps_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.head          (q_item),
		.q_stat        (q_stat),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.next_velocity (next_velocity)
	);

endmodule

/* design/vps_front.sv */
module vps_front (
	input  logic                clk,
	input  logic                arst_n,
	input  vps_pkg::cfg_t       cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [31:0]  displacement_to_goal,
	input  logic signed [31:0]  actual_velocity,
	input  logic signed [31:0]  speed_target_now,
	input  logic [30:0]         speed_target_dest,
	input  logic                q_full,
	output logic                push,
	output vps_pkg::item_t      item
);

	logic               vsmall;
	logic signed [31:0] vz;
	logic [31:0]        vz_u, s_u, now_u;
	logic [31:0]        vmag, smag, nowmag;
	logic signed [32:0] vplus;
	logic [32:0]        vplus_u, pmag;
	logic [47:0]        prod_amax, prod_anom;
	logic               load;
	logic               valid_s1;
	vps_pkg::item_t     nxt, item_s1;

	// zero small velocities, sort the beat into brake or profile
	always_comb begin
		vsmall = (actual_velocity > -vps_pkg::VelEps) && (actual_velocity < vps_pkg::VelEps);
		vz     = vsmall ? 32'sd0 : actual_velocity;
		vz_u   = vz;
		s_u    = displacement_to_goal;
		now_u  = speed_target_now;
		vmag   = vz[31] ? (32'd0 - vz_u) : vz_u;
		smag   = s_u[31] ? (32'd0 - s_u) : s_u;
		nowmag = now_u[31] ? (32'd0 - now_u) : now_u;
		vplus   = {vz[31], vz} + $signed({2'b00, cfg.accel_nominal});
		vplus_u = vplus;
		pmag    = vplus[32] ? (33'd0 - vplus_u) : vplus_u;
		prod_amax = 48'(cfg.accel_max) * 48'(cfg.dt);
		prod_anom = 48'(cfg.accel_nominal) * 48'(cfg.dt);

		nxt.s       = displacement_to_goal;
		nxt.vz      = vz;
		nxt.vmag    = vmag;
		nxt.smag    = smag;
		nxt.brake   = (displacement_to_goal == 32'sd0) ||
		              ((vz != 32'sd0) && (vz[31] != displacement_to_goal[31]));
		nxt.dest    = speed_target_dest;
		nxt.lim_now = (nowmag > {1'b0, cfg.speed_max}) ? cfg.speed_max : nowmag[30:0];
		nxt.dest_sq = 62'(speed_target_dest) * 62'(speed_target_dest);
		nxt.v_sq    = 64'(vmag) * 64'(vmag);
		nxt.lim_brake = prod_amax[47:16];
		nxt.climit    = prod_anom[47:16];
		nxt.p         = 50'(pmag) * 50'(cfg.dt);
	end

	assign load     = !valid_s1 || !q_full;
	assign in_stall = valid_s1 && q_full;
	assign push     = valid_s1 && !q_full;
	assign item     = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (load)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (load && in_valid)
			item_s1 <= nxt;
	end

endmodule

/* design/vps_fifo.sv */
`include "velocity_profile_step_macros.svh"

module vps_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  vps_pkg::item_t      wr_item,
	input  logic                pop,
	output vps_pkg::item_t      rd_item,
	output vps_pkg::fifo_stat_t stat
);

	vps_pkg::item_t                 mem [vps_pkg::FifoDepth];
	logic [vps_pkg::FifoPtrW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [vps_pkg::FifoCntW-1:0]   count_q;

	assign stat.full  = (count_q == vps_pkg::FifoCntW'(vps_pkg::FifoDepth));
	assign stat.empty = (count_q == '0);
	assign rd_item    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= wr_item;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	`VPS_ASSERT(a_no_push_full, !(push && stat.full), "push into full queue")
	`VPS_ASSERT(a_no_pop_empty, !(pop && stat.empty), "pop from empty queue")
	`VPS_ASSERT_NEXT(a_cnt_up, push && !pop, count_q == $past(count_q) + 3'd1, "fill level lost a push")
	`VPS_ASSERT(a_ptr_gap, (wr_ptr_q - rd_ptr_q) == count_q[vps_pkg::FifoPtrW-1:0], "pointers disagree with level")

endmodule

/* design/vps_back.sv */
module vps_back (
	input  logic                clk,
	input  logic                arst_n,
	input  vps_pkg::cfg_t       cfg,
	input  vps_pkg::item_t      head,
	input  vps_pkg::fifo_stat_t q_stat,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  next_velocity
);

	typedef struct packed {
		logic signed [31:0] vz;
		logic               sneg;
		logic               brake;
		logic signed [31:0] res_brake;
		logic               near;
		logic [30:0]        lim_now;
		logic [30:0]        dest;
		logic [31:0]        climit;
		logic [31:0]        smag;
		logic [32:0]        den;
		logic signed [63:0] num;
		logic               numneg;
		logic [62:0]        num_mag;
		logic               ovf1;
		logic               ovf2;
		logic [62:0]        r1;
		logic [30:0]        q1;
		logic [47:0]        r2;
		logic [33:0]        q2;
	} back_t;

	typedef struct packed {
		logic               brake;
		logic signed [31:0] res_brake;
		logic signed [31:0] vz;
		logic               take_acc;
		logic               reqneg;
		logic [31:0]        st;
		logic signed [35:0] change;
		logic [31:0]        climit;
	} fin_t;

	localparam int ND = vps_pkg::Q2Bits;

	logic   adv;
	logic   vld_s1, vld_s2, vld_s3, vld_s5;
	logic   vld_s4 [ND];
	back_t  num_s1, mag_s2, pre_s3;
	back_t  div_s4 [ND];
	fin_t   fin_s5;
	back_t  ld, mg, pr;
	fin_t   fn;
	logic   out_valid_q;
	logic signed [31:0] res_q;

	assign adv = !out_valid_q || !out_stall;
	assign pop = adv && !q_stat.empty;

	// first back stage: difference of squares, brake result, near-goal test
	always_comb begin
		logic [31:0] diff;
		ld = '0;
		diff = (head.vmag > head.lim_brake) ? head.lim_brake : head.vmag;
		ld.vz        = head.vz;
		ld.sneg      = head.s[31];
		ld.brake     = head.brake;
		ld.res_brake = head.vz[31] ? (head.vz + $signed(diff)) : (head.vz - $signed(diff));
		ld.near      = head.p > {2'b00, head.smag, 16'd0};
		ld.lim_now   = head.lim_now;
		ld.dest      = head.dest;
		ld.climit    = head.climit;
		ld.smag      = head.smag;
		ld.den       = {head.smag, 1'b0};
		ld.num       = $signed({2'b00, head.dest_sq}) - $signed(head.v_sq);
	end

	// magnitude of the numerator
	always_comb begin
		logic [63:0] nu;
		mg = num_s1;
		nu = num_s1.num;
		mg.numneg  = num_s1.num[63];
		mg.num_mag = num_s1.num[63] ? 63'(64'd0 - nu) : nu[62:0];
	end

	// quotient range checks and divider seeds
	always_comb begin
		pr = mag_s2;
		pr.ovf1 = {1'b0, mag_s2.num_mag} >= {mag_s2.den, 31'd0};
		pr.ovf2 = {4'd0, mag_s2.smag, 16'd0} >= {1'b0, cfg.dt, 34'd0};
		pr.r1   = mag_s2.num_mag;
		pr.r2   = {mag_s2.smag, 16'd0};
		pr.q1   = '0;
		pr.q2   = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= !q_stat.empty;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1 <= ld;
			mag_s2 <= mg;
			pre_s3 <= pr;
		end
	end

	// restoring division: per stage one q2 bit, and one q1 bit if any left
	for (genvar k = 0; k < ND; k++) begin : g_div
		localparam int B2 = ND - 1 - k;
		localparam int B1 = vps_pkg::Q1Bits - 1 - k;
		back_t src, nxt;
		logic  src_v;
		logic [51:0] d2;

		if (k == 0) begin : g_first
			assign src   = pre_s3;
			assign src_v = vld_s3;
		end else begin : g_next
			assign src   = div_s4[k-1];
			assign src_v = vld_s4[k-1];
		end

		if (k < vps_pkg::Q1Bits) begin : g_both
			logic [63:0] d1;
			always_comb begin
				nxt = src;
				d1 = 64'(src.den) << B1;
				d2 = 52'(cfg.dt) << B2;
				if ({1'b0, src.r1} >= d1) begin
					nxt.r1     = src.r1 - d1[62:0];
					nxt.q1[B1] = 1'b1;
				end
				if ({4'd0, src.r2} >= d2) begin
					nxt.r2     = src.r2 - d2[47:0];
					nxt.q2[B2] = 1'b1;
				end
			end
		end else begin : g_q2
			always_comb begin
				nxt = src;
				d2 = 52'(cfg.dt) << B2;
				if ({4'd0, src.r2} >= d2) begin
					nxt.r2     = src.r2 - d2[47:0];
					nxt.q2[B2] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s4[k] <= 1'b0;
			else if (adv)
				vld_s4[k] <= src_v;
		end

		always_ff @(posedge clk) begin
			if (adv)
				div_s4[k] <= nxt;
		end
	end

	// pick acceleration or slew, form the step
	always_comb begin
		back_t       x;
		logic [30:0] qsel;
		logic [47:0] prod;
		logic [33:0] q2s, lim;
		logic signed [35:0] tgt;
		x    = div_s4[ND-1];
		qsel = (x.ovf1 || (x.q1 > cfg.accel_max)) ? cfg.accel_max : x.q1;
		prod = 48'(qsel) * 48'(cfg.dt);
		q2s  = x.ovf2 ? '1 : x.q2;
		if (x.near)
			lim = (q2s > {3'd0, x.dest}) ? q2s : {3'd0, x.dest};
		else
			lim = {3'd0, x.lim_now};
		tgt = x.sneg ? -$signed({2'b00, lim}) : $signed({2'b00, lim});
		fn.brake     = x.brake;
		fn.res_brake = x.res_brake;
		fn.vz        = x.vz;
		fn.take_acc  = qsel >= cfg.accel_nominal;
		fn.reqneg    = x.numneg != x.sneg;
		fn.st        = prod[47:16];
		fn.change    = tgt - 36'(x.vz);
		fn.climit    = x.climit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s5 <= 1'b0;
		else if (adv)
			vld_s5 <= vld_s4[ND-1];
	end

	always_ff @(posedge clk) begin
		if (adv)
			fin_s5 <= fn;
	end

	// final sum, saturation, output register
	logic signed [31:0] res_d;
	always_comb begin
		logic signed [39:0] racc, rsl, vze, ste;
		logic signed [35:0] cl, chg;
		vze = 40'(fin_s5.vz);
		ste = $signed({8'd0, fin_s5.st});
		racc = fin_s5.reqneg ? (vze - ste) : (vze + ste);
		cl = $signed({4'd0, fin_s5.climit});
		if (fin_s5.change > cl)
			chg = cl;
		else if (fin_s5.change < -cl)
			chg = -cl;
		else
			chg = fin_s5.change;
		rsl = vze + 40'(chg);
		if (fin_s5.brake)
			res_d = fin_s5.res_brake;
		else if (fin_s5.take_acc)
			res_d = vps_pkg::sat32(racc);
		else
			res_d = vps_pkg::sat32(rsl);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= vld_s5;
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_q <= res_d;
	end

	assign out_valid     = out_valid_q;
	assign next_velocity = res_q;

endmodule
